### src/pfa_pkg.sv
// Package with shared types, state codes and sector arithmetic for the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  // Controller states: idle waits for a request, calc consumes the metadata read.
  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  // Outcome of the frame selection.
  typedef struct packed {
    logic avail;  // a free or an unpinned frame exists
    logic evict;  // no free frame, the chosen one is an eviction victim
  } pfa_pick_t;

  // Update of the frame flags once a request is committed.
  typedef struct packed {
    logic en;
    logic pinned;
  } pfa_upd_t;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned EndW   = AddrW + 1;
  localparam int unsigned CntW   = 4;
  localparam int unsigned MetaW  = 3 * AddrW;

  // First disk sector of the page that holds vaddr.
  function automatic logic [AddrW-1:0] page_sector(
    input logic [AddrW-1:0] vaddr,
    input logic [AddrW-1:0] base,
    input logic [AddrW-1:0] start,
    input logic [4:0]       page_shift,
    input logic [4:0]       sector_shift
  );
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] offs;
    mask = (AddrW'(1) << page_shift) - AddrW'(1);
    offs = (vaddr & ~mask) - start;
    return base + (offs >> sector_shift);
  endfunction

  // Sectors of one page, clipped at the image end and saturated at zero.
  function automatic logic [CntW-1:0] page_count(
    input logic [AddrW-1:0] sector,
    input logic [EndW-1:0]  img_end,
    input logic [EndW:0]    per_page
  );
    logic [EndW:0] sum;
    logic [EndW:0] diff;
    sum  = {2'b00, sector} + per_page;
    diff = {1'b0, img_end} - {2'b00, sector};
    if (sum <= {1'b0, img_end}) begin
      return per_page[CntW-1:0];
    end else if (img_end > {1'b0, sector}) begin
      return diff[CntW-1:0];
    end else begin
      return '0;
    end
  endfunction

endpackage

`default_nettype wire

### src/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/pfa_frame_tbl.sv
// Free and pinned flags of all frames with lowest-free / lowest-unpinned selection.
`timescale 1ns / 1ps
`default_nettype none

module pfa_frame_tbl import pfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pfa_upd_t                      upd_i,
  input  wire logic [$clog2(NUM_FRAMES)-1:0] upd_idx_i,
  output pfa_pick_t                          pick_o,
  output logic      [$clog2(NUM_FRAMES)-1:0] pick_idx_o
);

  localparam int unsigned IdxW = $clog2(NUM_FRAMES);

  logic [NUM_FRAMES-1:0] free_q;
  logic [NUM_FRAMES-1:0] pinned_q;
  logic [NUM_FRAMES-1:0] cand;
  logic [NUM_FRAMES-1:0] lowest;
  logic                  any_free;
  logic [IdxW-1:0]       idx;

  // Flag update when a request commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q   <= '1;
      pinned_q <= '0;
    end else if (upd_i.en) begin
      free_q[upd_idx_i]   <= 1'b0;
      pinned_q[upd_idx_i] <= upd_i.pinned;
    end
  end

  // Candidates are free frames, or unpinned ones when nothing is free.
  always_comb begin
    any_free = |free_q;
    cand     = any_free ? free_q : ~pinned_q;
    lowest   = cand & (~cand + NUM_FRAMES'(1));
  end

  // Encode the one-hot lowest candidate.
  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (lowest[i]) begin
        idx = idx | IdxW'(i);
      end
    end
  end

  assign pick_o.avail = |cand;
  assign pick_o.evict = ~any_free;
  assign pick_idx_o   = idx;

endmodule

`default_nettype wire

### src/page_frame_allocator.sv
// Top level of the page frame allocator: control, metadata memory and result pipeline.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tuser: is_fault; tdata: request fields
// m_axis    out  m_axis_tvalid/tready       tuser: ok, evicted; tdata: result fields
// cfg       in   cfg_we_i                   cfg_wdata_i: physical base of frame 0
//
// A request passes two states: idle selects a frame and reads its metadata entry, and
// compute calculates the sectors and writes new metadata back for a granted fault.
// A third stage computes sector counts and frame address while the next one is selected.
// Reset clears the frame flags at once; the metadata memory is not cleared.
// A stalled output holds its word; the pipeline behind it stalls in the compute state.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_allocator import pfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES   = 32,
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [0] is_fault
  input  wire logic [0:0]   s_axis_tuser,
  // [31:0] fault_vaddr, [63:32] swap_base, [95:64] swap_len, [127:96] image_start
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] ok, [1] evicted
  output logic [1:0]        m_axis_tuser,
  // [4:0] frame_index, [36:5] frame_addr, [68:37] wb_sector, [72:69] wb_count,
  // [104:73] flush_vaddr, [136:105] rd_sector, [140:137] rd_count, [143:141] zero
  output logic [143:0]      m_axis_tdata
);

  localparam int unsigned IdxW        = $clog2(NUM_FRAMES);
  localparam int unsigned PageShift   = $clog2(PAGE_BYTES);
  localparam int unsigned SectorShift = $clog2(SECTOR_BYTES);
  localparam int unsigned PerPage     = PAGE_BYTES / SECTOR_BYTES;

  // Control and frame selection.
  state_e    state_q, state_d;
  pfa_pick_t pick;
  logic [IdxW-1:0] pick_idx;
  pfa_upd_t  upd;
  logic      accept;
  logic      calc_adv;
  logic      ram_we;
  logic      ram_re;

  // Request stage registers.
  logic            fault_q;
  logic [31:0]     fvaddr_q, sbase_q, slen_q, istart_q;
  logic [IdxW-1:0] idx_q;
  logic            avail_q, evict_q;
  logic [31:0]     base_addr_q;

  // Metadata read back from memory.
  logic [MetaW-1:0] meta_rd;
  logic [31:0]      m_vaddr, m_base, m_len;

  // Count stage registers.
  logic            s2_valid_q;
  logic            s2_ok_q, s2_evict_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [31:0]     s2_wb_sec_q, s2_flush_q, s2_rd_sec_q;
  logic [EndW-1:0] s2_wb_end_q, s2_rd_end_q;
  logic            s2_adv, s2_free;

  // Output register.
  logic         out_valid_q;
  logic [1:0]   out_user_q;
  logic [143:0] out_data_q;
  logic         out_free;
  logic [31:0]  idx_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_adv   = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || s2_adv;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_addr_q <= 32'h0010_0000;
    end else if (cfg_we_i) begin
      base_addr_q <= cfg_wdata_i;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (s2_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    calc_adv      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CALC: calc_adv      = s2_free;
      default: ;
    endcase
  end

  pfa_frame_tbl #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_frame_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .upd_idx_i (idx_q),
    .pick_o    (pick),
    .pick_idx_o(pick_idx)
  );

  // Commit the request when it leaves the compute state.
  assign upd.en     = calc_adv && avail_q;
  assign upd.pinned = !fault_q;
  assign ram_we     = calc_adv && avail_q && fault_q;
  assign ram_re     = accept;

  pfa_ram #(
    .WIDTH(MetaW),
    .DEPTH(NUM_FRAMES)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i({slen_q, sbase_q, fvaddr_q}),
    .re_i   (ram_re),
    .raddr_i(pick_idx),
    .rdata_o(meta_rd)
  );

  assign m_vaddr = meta_rd[31:0];
  assign m_base  = meta_rd[63:32];
  assign m_len   = meta_rd[95:64];

  // Capture the request and the selection outcome.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q  <= s_axis_tuser[0];
      fvaddr_q <= s_axis_tdata[31:0];
      sbase_q  <= s_axis_tdata[63:32];
      slen_q   <= s_axis_tdata[95:64];
      istart_q <= s_axis_tdata[127:96];
      idx_q    <= pick_idx;
      avail_q  <= pick.avail;
      evict_q  <= pick.evict;
    end
  end

  // Count stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (calc_adv) begin
      s2_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  // Sectors and image ends of the victim and of the fault page.
  always_ff @(posedge clk_i) begin
    if (calc_adv) begin
      s2_ok_q    <= avail_q;
      s2_evict_q <= avail_q && evict_q;
      s2_idx_q   <= avail_q ? idx_q : '0;
      if (avail_q && evict_q) begin
        s2_wb_sec_q <= page_sector(m_vaddr, m_base, istart_q, 5'(PageShift),
                                   5'(SectorShift));
        s2_wb_end_q <= {1'b0, m_base} + {1'b0, m_len};
        s2_flush_q  <= m_vaddr;
      end else begin
        s2_wb_sec_q <= '0;
        s2_wb_end_q <= '0;
        s2_flush_q  <= '0;
      end
      if (avail_q && fault_q) begin
        s2_rd_sec_q <= page_sector(fvaddr_q, sbase_q, istart_q, 5'(PageShift),
                                   5'(SectorShift));
        s2_rd_end_q <= {1'b0, sbase_q} + {1'b0, slen_q};
      end else begin
        s2_rd_sec_q <= '0;
        s2_rd_end_q <= '0;
      end
    end
  end

  assign idx_ext = 32'(s2_idx_q);

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Counts, frame address and packing into the output word.
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_user_q <= {s2_evict_q, s2_ok_q};
      out_data_q <= {
        3'b000,
        page_count(s2_rd_sec_q, s2_rd_end_q, (EndW + 1)'(PerPage)),
        s2_rd_sec_q,
        s2_flush_q,
        page_count(s2_wb_sec_q, s2_wb_end_q, (EndW + 1)'(PerPage)),
        s2_wb_sec_q,
        s2_ok_q ? base_addr_q + (idx_ext << PageShift) : 32'd0,
        idx_ext[4:0]
      };
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // An accepted request always moves to the compute state.
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CALC)
    else $error("accepted request did not enter compute state");

  // Metadata is written only for a granted fault request.
  a_write_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (fault_q && avail_q && state_q == ST_CALC))
    else $error("metadata write without granted fault request");

  // An eviction is never reported without a grant.
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("eviction reported on a failed request");

  // A failed request carries an all-zero result word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("failed request has nonzero result fields");

  // The count stage cannot be overwritten while it still holds a word.
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |-> !calc_adv)
    else $error("count stage overwritten while stalled");
`endif

endmodule

`default_nettype wire
